// ----- rtl/core/pjq_pkg.sv -----
// Shared types, constants and codes for the priority job queue.
`timescale 1ns / 1ps
package pjq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Result status codes
    localparam logic [1:0] ST_ENTRY = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Request modes as they arrive on the input channel
    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_POP   = 3'd1;
    localparam logic [2:0] MODE_LUSER = 3'd2;
    localparam logic [2:0] MODE_LCAP  = 3'd3;
    localparam logic [2:0] MODE_LALL  = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    // Classified commands handed from front to back
    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_POP,
        CMD_LUSER,
        CMD_LCAP,
        CMD_LALL,
        CMD_CLEAR,
        CMD_NOP
    } cmd_op_t;

    // One stored job (also carries the limits of a capacity listing)
    typedef struct packed {
        logic [15:0] prio;
        logic [15:0] run_time;
        logic [15:0] memory;
        logic [7:0]  gpus;
        logic [7:0]  cpus;
        logic [31:0] user;
        logic [31:0] job;
    } entry_t;

    typedef struct packed {
        cmd_op_t op;
        entry_t  ent;
    } cmd_t;

endpackage

// ----- rtl/core/pjq_front.sv -----
// Front end: accepts requests, classifies the mode and queues commands.
`timescale 1ns / 1ps
module pjq_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    in_mode,
    input  pjq_pkg::entry_t in_ent,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output pjq_pkg::cmd_t cmd
);

    pjq_pkg::cmd_t   fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    pjq_pkg::cmd_op_t op;
    logic            push, pop;

    // Classify the request mode
    always_comb begin
        case (in_mode)
            pjq_pkg::MODE_ADD:   op = pjq_pkg::CMD_ADD;
            pjq_pkg::MODE_POP:   op = pjq_pkg::CMD_POP;
            pjq_pkg::MODE_LUSER: op = pjq_pkg::CMD_LUSER;
            pjq_pkg::MODE_LCAP:  op = pjq_pkg::CMD_LCAP;
            pjq_pkg::MODE_LALL:  op = pjq_pkg::CMD_LALL;
            pjq_pkg::MODE_CLEAR: op = pjq_pkg::CMD_CLEAR;
            default:             op = pjq_pkg::CMD_NOP;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{op: op, ent: in_ent};
        end
    end

endmodule

// ----- rtl/core/pjq_back.sv -----
// Back end: sorted job store, insert/pop/list sequencer and result register.
`timescale 1ns / 1ps
module pjq_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  pjq_pkg::cmd_t   cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      out_status,
    output pjq_pkg::entry_t out_ent,
    output logic            out_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_EV,
        S_POP_OUT,
        S_SH_CHK,
        S_SH_WR,
        S_LS_CHK,
        S_LS_EV,
        S_LS_FIN,
        S_STAT
    } state_t;

    state_t                        state_reg;
    pjq_pkg::cmd_t                 cmd_reg;
    logic [pjq_pkg::CNT_W-1:0]     fill_reg;
    logic [pjq_pkg::CNT_W-1:0]     idx_reg;
    logic [pjq_pkg::CNT_W-1:0]     idx_dec;
    logic [pjq_pkg::NRES_W-1:0]    nres_reg;
    pjq_pkg::entry_t               pend_reg;
    logic                          pend_vld_reg;
    logic [1:0]                    stat_reg;
    logic                          out_valid_reg;
    logic [1:0]                    out_status_reg;
    pjq_pkg::entry_t               out_ent_reg;
    logic                          out_last_reg;

    pjq_pkg::entry_t               mem [pjq_pkg::QUEUE_DEPTH];
    pjq_pkg::entry_t               rd_data_reg;
    logic                          mem_we, mem_re;
    logic [pjq_pkg::ADDR_W-1:0]    mem_wa, mem_ra;
    pjq_pkg::entry_t               mem_wd;

    logic                          out_free;
    logic                          out_load;
    logic                          hit;
    logic                          scan_end;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_ent    = out_ent_reg;
    assign out_last   = out_last_reg;
    assign cmd_ready  = (state_reg == S_IDLE);
    assign idx_dec    = idx_reg - pjq_pkg::CNT_W'(1);

    // Match test of a listing against the entry just read
    always_comb begin
        case (cmd_reg.op)
            pjq_pkg::CMD_LUSER: hit = (rd_data_reg.user == cmd_reg.ent.user);
            pjq_pkg::CMD_LCAP:  hit = (rd_data_reg.cpus <= cmd_reg.ent.cpus) &&
                                      (rd_data_reg.gpus <= cmd_reg.ent.gpus) &&
                                      (rd_data_reg.memory <= cmd_reg.ent.memory) &&
                                      (rd_data_reg.run_time <= cmd_reg.ent.run_time);
            default:            hit = 1'b1;
        endcase
    end

    assign scan_end = (idx_reg >= fill_reg) ||
                      (nres_reg == pjq_pkg::NRES_W'(pjq_pkg::MAX_RESULTS));

    // Result register gets a new result this cycle
    assign out_load = out_free &&
                      ((state_reg == S_POP_OUT) || (state_reg == S_LS_FIN) ||
                       (state_reg == S_STAT) ||
                       ((state_reg == S_LS_EV) && hit && pend_vld_reg));

    // Store port controls
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = idx_reg[pjq_pkg::ADDR_W-1:0];
        mem_ra = idx_reg[pjq_pkg::ADDR_W-1:0];
        mem_wd = cmd_reg.ent;
        case (state_reg)
            S_INS_CHK: begin
                if (idx_reg == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = idx_dec[pjq_pkg::ADDR_W-1:0];
                end
            end
            S_INS_EV: begin
                mem_we = 1'b1;
                if (rd_data_reg.prio < cmd_reg.ent.prio) begin
                    mem_wd = rd_data_reg;
                end
            end
            S_DISPATCH: begin
                mem_re = (cmd_reg.op == pjq_pkg::CMD_POP) && (fill_reg != '0);
                mem_ra = '0;
            end
            S_SH_CHK: begin
                mem_re = (idx_reg < fill_reg);
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                mem_wa = idx_dec[pjq_pkg::ADDR_W-1:0];
                mem_wd = rd_data_reg;
            end
            S_LS_CHK: begin
                mem_re = !scan_end;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Job store with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end else begin
            if (out_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg   <= cmd;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    nres_reg     <= '0;
                    pend_vld_reg <= 1'b0;
                    case (cmd_reg.op)
                        pjq_pkg::CMD_ADD: begin
                            if (fill_reg == pjq_pkg::CNT_W'(pjq_pkg::QUEUE_DEPTH)) begin
                                idx_reg   <= '0;
                                stat_reg  <= pjq_pkg::ST_FULL;
                                state_reg <= S_STAT;
                            end else begin
                                idx_reg   <= fill_reg;
                                state_reg <= S_INS_CHK;
                            end
                        end
                        pjq_pkg::CMD_POP: begin
                            idx_reg <= '0;
                            if (fill_reg == '0) begin
                                stat_reg  <= pjq_pkg::ST_EMPTY;
                                state_reg <= S_STAT;
                            end else begin
                                state_reg <= S_POP_OUT;
                            end
                        end
                        pjq_pkg::CMD_LUSER, pjq_pkg::CMD_LCAP, pjq_pkg::CMD_LALL: begin
                            idx_reg <= '0;
                            if (fill_reg == '0) begin
                                stat_reg  <= pjq_pkg::ST_EMPTY;
                                state_reg <= S_STAT;
                            end else begin
                                state_reg <= S_LS_CHK;
                            end
                        end
                        pjq_pkg::CMD_CLEAR: begin
                            idx_reg   <= '0;
                            fill_reg  <= '0;
                            stat_reg  <= pjq_pkg::ST_DONE;
                            state_reg <= S_STAT;
                        end
                        default: begin
                            idx_reg   <= '0;
                            stat_reg  <= pjq_pkg::ST_DONE;
                            state_reg <= S_STAT;
                        end
                    endcase
                end
                // Walk down from the tail, shifting lower-priority jobs up
                S_INS_CHK: begin
                    if (idx_reg == '0) begin
                        fill_reg  <= fill_reg + pjq_pkg::CNT_W'(1);
                        stat_reg  <= pjq_pkg::ST_DONE;
                        state_reg <= S_STAT;
                    end else begin
                        state_reg <= S_INS_EV;
                    end
                end
                S_INS_EV: begin
                    if (rd_data_reg.prio >= cmd_reg.ent.prio) begin
                        fill_reg  <= fill_reg + pjq_pkg::CNT_W'(1);
                        stat_reg  <= pjq_pkg::ST_DONE;
                        state_reg <= S_STAT;
                    end else begin
                        idx_reg   <= idx_dec;
                        state_reg <= S_INS_CHK;
                    end
                end
                // Report the head, then close the gap
                S_POP_OUT: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= pjq_pkg::ST_ENTRY;
                        out_ent_reg    <= rd_data_reg;
                        out_last_reg   <= 1'b1;
                        idx_reg        <= pjq_pkg::CNT_W'(1);
                        state_reg      <= S_SH_CHK;
                    end
                end
                S_SH_CHK: begin
                    if (idx_reg < fill_reg) begin
                        state_reg <= S_SH_WR;
                    end else begin
                        fill_reg  <= fill_reg - pjq_pkg::CNT_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
                S_SH_WR: begin
                    idx_reg   <= idx_reg + pjq_pkg::CNT_W'(1);
                    state_reg <= S_SH_CHK;
                end
                // Scan entries; hold one match back so the final one can carry last
                S_LS_CHK: begin
                    if (scan_end) begin
                        if (pend_vld_reg) begin
                            state_reg <= S_LS_FIN;
                        end else begin
                            stat_reg  <= pjq_pkg::ST_DONE;
                            state_reg <= S_STAT;
                        end
                    end else begin
                        state_reg <= S_LS_EV;
                    end
                end
                S_LS_EV: begin
                    if (!hit) begin
                        idx_reg   <= idx_reg + pjq_pkg::CNT_W'(1);
                        state_reg <= S_LS_CHK;
                    end else if (!pend_vld_reg || out_free) begin
                        if (pend_vld_reg) begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= pjq_pkg::ST_ENTRY;
                            out_ent_reg    <= pend_reg;
                            out_last_reg   <= 1'b0;
                        end
                        pend_reg     <= rd_data_reg;
                        pend_vld_reg <= 1'b1;
                        nres_reg     <= nres_reg + pjq_pkg::NRES_W'(1);
                        idx_reg      <= idx_reg + pjq_pkg::CNT_W'(1);
                        state_reg    <= S_LS_CHK;
                    end
                end
                S_LS_FIN: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= pjq_pkg::ST_ENTRY;
                        out_ent_reg    <= pend_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= stat_reg;
                        out_ent_reg    <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/priority_job_queue_top.sv -----
// Top level of the priority job queue: stream ports, front end and back end.
//
//  Channel | Dir | Ports                      | Carries
//  s_      | in  | s_tvalid/s_tready/s_tdata  | one request (mode and job fields)
//  m_      | out | m_tvalid/m_tready/m_tdata  | one result (status and entry), tlast
//
// An add moves each stored job of lower priority up one place, a pop moves
// every remaining stored job down one place, and a listing scans stored
// jobs from the head; all take longer while m_tready stalls. The job store
// has one write port and one registered read port.
// Reset empties the queue; stored job contents are not cleared.
// Up to two requests queue ahead of the sequencer; the result register
// lets the sequencer move on while a result waits for m_tready.
`timescale 1ns / 1ps
module priority_job_queue_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], job_tag[34:3], user_tag[66:35], cpu_count[74:67],
    // gpu_count[82:75], memory_amount[98:83], run_time[114:99],
    // priority_level[130:115], zero fill above
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_status[1:0], out_job_tag[33:2], out_user_tag[65:34], out_cpus[73:66],
    // out_gpus[81:74], out_memory[97:82], out_time[113:98],
    // out_priority[129:114], zero fill above
    output logic [135:0] m_tdata,
    output logic         m_tlast
);

    pjq_pkg::entry_t in_ent;
    pjq_pkg::entry_t out_ent;
    pjq_pkg::cmd_t   cmd;
    logic            cmd_valid, cmd_ready;
    logic [1:0]      out_status;

    // Unpack the request
    always_comb begin
        in_ent.job      = s_tdata[34:3];
        in_ent.user     = s_tdata[66:35];
        in_ent.cpus     = s_tdata[74:67];
        in_ent.gpus     = s_tdata[82:75];
        in_ent.memory   = s_tdata[98:83];
        in_ent.run_time = s_tdata[114:99];
        in_ent.prio     = s_tdata[130:115];
    end

    pjq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tdata[2:0]),
        .in_ent    (in_ent),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    pjq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_ent    (out_ent),
        .out_last   (m_tlast)
    );

    // Pack the result
    assign m_tdata = {6'd0, out_ent.prio, out_ent.run_time, out_ent.memory,
                      out_ent.gpus, out_ent.cpus, out_ent.user, out_ent.job,
                      out_status};

endmodule

// ----- rtl/core/pjq_checker.sv -----
// Port-level checks on the priority job queue, bound to the top level.
`timescale 1ns / 1ps
module pjq_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Status-only results carry zero entry fields
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != pjq_pkg::ST_ENTRY) |-> (m_tdata[135:2] == '0))
        else $error("status result carries entry data");

    // A status-only result always ends its request
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != pjq_pkg::ST_ENTRY) |-> m_tlast)
        else $error("status result without last");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind priority_job_queue_top pjq_checker u_pjq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
